FILE: sv/vpo_pkg.sv
package vpo_pkg;

   localparam int CV_W      = 16;
   localparam int VOICE_W   = 3;
   localparam int MODE_W    = 2;
   localparam int OCT_W     = 3;
   localparam int SR_W      = 18;
   localparam int CONV_W    = 40;
   localparam int CSR_IDX_W = 2;

   localparam int FRAC_W    = 16;
   localparam int MANT_W    = 31;
   localparam int MANT_Q    = 30;
   localparam int SHIFT_W   = 5;
   localparam int EB_W      = 23;
   localparam int EXP_INT_W = EB_W - FRAC_W;
   localparam int DIV_W     = 55;
   localparam int RND_SHIFT = 21;
   localparam int RAW_W     = DIV_W - RND_SHIFT;

   localparam logic [MODE_W-1:0] MODE_HZ  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_20K = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SR   = 2'd2;

   localparam logic [SR_W-1:0] SR_RESET = 18'd48000;
   localparam logic [SR_W-1:0] DIV_20K  = 18'd20000;
   localparam logic [SR_W-1:0] DIV_ONE  = 18'd1;

   // 5.0313842 in Q16 plus a 16 octave bias that keeps the exponent positive
   localparam logic [EB_W-1:0] EXP_BIAS = 23'd1378313;
   localparam logic [EXP_INT_W-1:0] SHIFT_BIAS = 7'd9;

   localparam logic [MANT_W-1:0]   MANT_ONE   = 31'd1 << MANT_Q;
   localparam logic [2*MANT_W-1:0] PROD_ROUND = 62'd1 << (MANT_Q - 1);
   localparam logic [DIV_W:0]      QUOT_ROUND = 56'd1 << (RND_SHIFT - 1);
   localparam logic [CONV_W-1:0]   CONV_MAX   = '1;

   typedef logic [MANT_W-1:0] root_tab_type [FRAC_W];

   typedef struct packed {
      logic [VOICE_W-1:0] voice;
      logic [SR_W-1:0]    divisor;
      logic               force_max;
      logic               force_zero;
   } side_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem_v;
      logic [63:0] res_v;
      logic [63:0] one_v;
      rem_v = x;
      res_v = '0;
      for (int i = 31; i >= 0; i--) begin
         one_v = 64'd1 << (2 * i);
         if (rem_v >= res_v + one_v) begin
            rem_v = rem_v - (res_v + one_v);
            res_v = (res_v >> 1) + one_v;
         end else begin
            res_v = res_v >> 1;
         end
      end
      return res_v;
   endfunction

   // Q30 roots 2^(2^-(k+1)), k = 0 for the top fraction bit
   function automatic root_tab_type root_table();
      root_tab_type tab;
      logic [63:0]  r;
      r = isqrt64(64'd1 << 61);
      tab[0] = r[MANT_W-1:0];
      for (int k = 1; k < FRAC_W; k++) begin
         r = isqrt64(r << MANT_Q);
         tab[k] = r[MANT_W-1:0];
      end
      return tab;
   endfunction

   localparam root_tab_type ROOTS = root_table();

endpackage

FILE: sv/vpo_exp2.sv
module vpo_exp2 (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [vpo_pkg::FRAC_W-1:0]   in_frac,
   input  logic [vpo_pkg::SHIFT_W-1:0]  in_shift,
   input  vpo_pkg::side_type            in_side,
   output logic                         out_valid,
   output logic [vpo_pkg::MANT_W-1:0]   out_mant,
   output logic [vpo_pkg::SHIFT_W-1:0]  out_shift,
   output vpo_pkg::side_type            out_side
);
   import vpo_pkg::*;

   logic                valid_ff [FRAC_W];
   logic [MANT_W-1:0]   mant_ff  [FRAC_W];
   logic [FRAC_W-1:0]   frac_ff  [FRAC_W];
   logic [SHIFT_W-1:0]  shift_ff [FRAC_W];
   side_type            side_ff  [FRAC_W];

   logic                src_valid [FRAC_W];
   logic [MANT_W-1:0]   src_mant  [FRAC_W];
   logic [FRAC_W-1:0]   src_frac  [FRAC_W];
   logic [SHIFT_W-1:0]  src_shift [FRAC_W];
   side_type            src_side  [FRAC_W];
   logic [2*MANT_W-1:0] prod      [FRAC_W];
   logic [MANT_W-1:0]   mant_in   [FRAC_W];

   always_comb begin
      src_valid[0] = in_valid;
      src_mant[0]  = MANT_ONE;
      src_frac[0]  = in_frac;
      src_shift[0] = in_shift;
      src_side[0]  = in_side;
      for (int k = 1; k < FRAC_W; k++) begin
         src_valid[k] = valid_ff[k-1];
         src_mant[k]  = mant_ff[k-1];
         src_frac[k]  = frac_ff[k-1];
         src_shift[k] = shift_ff[k-1];
         src_side[k]  = side_ff[k-1];
      end
      for (int k = 0; k < FRAC_W; k++) begin
         prod[k] = (2*MANT_W)'(src_mant[k]) * (2*MANT_W)'(ROOTS[k]) + PROD_ROUND;
         mant_in[k] = src_frac[k][FRAC_W-1-k] ? prod[k][MANT_W+MANT_Q-1:MANT_Q]
                                               : src_mant[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < FRAC_W; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= src_valid[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < FRAC_W; k++) begin
            mant_ff[k]  <= mant_in[k];
            frac_ff[k]  <= src_frac[k];
            shift_ff[k] <= src_shift[k];
            side_ff[k]  <= src_side[k];
         end
      end
   end

   assign out_valid = valid_ff[FRAC_W-1];
   assign out_mant  = mant_ff[FRAC_W-1];
   assign out_shift = shift_ff[FRAC_W-1];
   assign out_side  = side_ff[FRAC_W-1];

endmodule

FILE: sv/vpo_div.sv
module vpo_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  logic [vpo_pkg::DIV_W-1:0]  in_dividend,
   input  vpo_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [vpo_pkg::DIV_W-1:0]  out_quot,
   output vpo_pkg::side_type          out_side
);
   import vpo_pkg::*;

   // one quotient bit per stage; dq shifts dividend out and quotient in
   logic             valid_ff [DIV_W];
   logic [SR_W-1:0]  rem_ff   [DIV_W];
   logic [DIV_W-1:0] dq_ff    [DIV_W];
   side_type         side_ff  [DIV_W];

   logic             src_valid [DIV_W];
   logic [SR_W-1:0]  src_rem   [DIV_W];
   logic [DIV_W-1:0] src_dq    [DIV_W];
   side_type         src_side  [DIV_W];
   logic [SR_W:0]    trial     [DIV_W];
   logic             take      [DIV_W];
   logic [SR_W:0]    diff      [DIV_W];
   logic [SR_W-1:0]  rem_in    [DIV_W];
   logic [DIV_W-1:0] dq_in     [DIV_W];

   always_comb begin
      src_valid[0] = in_valid;
      src_rem[0]   = '0;
      src_dq[0]    = in_dividend;
      src_side[0]  = in_side;
      for (int j = 1; j < DIV_W; j++) begin
         src_valid[j] = valid_ff[j-1];
         src_rem[j]   = rem_ff[j-1];
         src_dq[j]    = dq_ff[j-1];
         src_side[j]  = side_ff[j-1];
      end
      for (int j = 0; j < DIV_W; j++) begin
         trial[j]  = {src_rem[j], src_dq[j][DIV_W-1]};
         take[j]   = trial[j] >= {1'b0, src_side[j].divisor};
         diff[j]   = trial[j] - {1'b0, src_side[j].divisor};
         rem_in[j] = take[j] ? diff[j][SR_W-1:0] : trial[j][SR_W-1:0];
         dq_in[j]  = {src_dq[j][DIV_W-2:0], take[j]};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_W; j++) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (enable) begin
            valid_ff[j] <= src_valid[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < DIV_W; j++) begin
            rem_ff[j]  <= rem_in[j];
            dq_ff[j]   <= dq_in[j];
            side_ff[j] <= src_side[j];
         end
      end
   end

   assign out_valid = valid_ff[DIV_W-1];
   assign out_quot  = dq_ff[DIV_W-1];
   assign out_side  = side_ff[DIV_W-1];

endmodule

FILE: sv/volt_per_octave_to_frequency_top.sv
// Pipeline: input stage, 16 exp2 multiply stages, shift stage, 55 restoring
// divide stages and an output register.
// Throughput: one request per cycle unless a held response stalls the pipeline.
// Reset (synchronous, active high) empties the pipeline and sets mode 0,
// octave offset 0 and sample rate 48000.
module volt_per_octave_to_frequency_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [vpo_pkg::CV_W-1:0]          req_cv_volts,
   input  logic [vpo_pkg::VOICE_W-1:0]       req_voice,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [vpo_pkg::CONV_W-1:0]        rsp_converted,
   output logic [vpo_pkg::VOICE_W-1:0]       rsp_voice_out,
   output logic                              rsp_saturated,
   input  logic                              csr_we,
   input  logic [vpo_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vpo_pkg::SR_W-1:0]          csr_wdata
);
   import vpo_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   logic [OCT_W-1:0]  oct_ff;
   logic [SR_W-1:0]   sr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HZ;
         oct_ff  <= '0;
         sr_ff   <= SR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE: mode_ff <= csr_wdata[MODE_W-1:0];
            CSR_OCT:  oct_ff  <= csr_wdata[OCT_W-1:0];
            CSR_SR:   sr_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic adv;
   logic div_valid;
   logic [DIV_W-1:0] div_quot;
   side_type div_side;

   assign adv       = !div_valid || !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // exponent and mode decode
   logic [EB_W-1:0]      eb_in;
   logic [SHIFT_W-1:0]   shift_in;
   side_type             side_in;
   logic                 is_sr;

   always_comb begin
      eb_in = {{(EB_W-OCT_W-FRAC_W){oct_ff[OCT_W-1]}}, oct_ff, {FRAC_W{1'b0}}}
            + {{(EB_W-CV_W-4){req_cv_volts[CV_W-1]}}, req_cv_volts, 4'd0}
            + EXP_BIAS;
      is_sr = (mode_ff == MODE_SR);
      shift_in = SHIFT_W'(eb_in[EB_W-1:FRAC_W] - SHIFT_BIAS + EXP_INT_W'(is_sr));
      side_in.voice      = req_voice;
      side_in.force_max  = 1'b0;
      side_in.force_zero = 1'b0;
      unique case (mode_ff)
         MODE_SR: begin
            side_in.divisor   = sr_ff;
            side_in.force_max = (sr_ff == '0);
         end
         MODE_20K: side_in.divisor = DIV_20K;
         MODE_HZ:  side_in.divisor = DIV_ONE;
         default: begin
            side_in.divisor    = DIV_ONE;
            side_in.force_zero = 1'b1;
         end
      endcase
   end

   logic               s0_valid_ff;
   logic [FRAC_W-1:0]  s0_frac_ff;
   logic [SHIFT_W-1:0] s0_shift_ff;
   side_type           s0_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_frac_ff  <= eb_in[FRAC_W-1:0];
         s0_shift_ff <= shift_in;
         s0_side_ff  <= side_in;
      end
   end

   logic               x_valid;
   logic [MANT_W-1:0]  x_mant;
   logic [SHIFT_W-1:0] x_shift;
   side_type           x_side;

   vpo_exp2 u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (s0_valid_ff),
      .in_frac   (s0_frac_ff),
      .in_shift  (s0_shift_ff),
      .in_side   (s0_side_ff),
      .out_valid (x_valid),
      .out_mant  (x_mant),
      .out_shift (x_shift),
      .out_side  (x_side)
   );

   logic             sh_valid_ff;
   logic [DIV_W-1:0] sh_num_ff;
   side_type         sh_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_valid_ff <= 1'b0;
      end else if (adv) begin
         sh_valid_ff <= x_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sh_num_ff  <= DIV_W'(x_mant) << x_shift;
         sh_side_ff <= x_side;
      end
   end

   vpo_div u_div (
      .clock       (clock),
      .reset       (reset),
      .enable      (adv),
      .in_valid    (sh_valid_ff),
      .in_dividend (sh_num_ff),
      .in_side     (sh_side_ff),
      .out_valid   (div_valid),
      .out_quot    (div_quot),
      .out_side    (div_side)
   );

   // round half up and drop the guard bits
   logic [DIV_W:0]      rnd_sum;
   logic [CONV_W-1:0]   conv_in;
   logic                sat_in;
   logic                out_load;
   logic                rsp_valid_in;
   logic                rsp_valid_ff;
   logic [CONV_W-1:0]   conv_ff;
   logic [VOICE_W-1:0]  voice_ff;
   logic                sat_ff;

   always_comb begin
      rnd_sum = {1'b0, div_quot} + QUOT_ROUND;
      if (div_side.force_zero) begin
         conv_in = '0;
         sat_in  = 1'b0;
      end else if (div_side.force_max) begin
         conv_in = CONV_MAX;
         sat_in  = 1'b1;
      end else begin
         conv_in = CONV_W'(rnd_sum[DIV_W:RND_SHIFT]);
         sat_in  = 1'b0;
      end
      out_load = div_valid && (!rsp_valid_ff || rsp_ready);
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         conv_ff  <= conv_in;
         voice_ff <= div_side.voice;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_converted = conv_ff;
   assign rsp_voice_out = voice_ff;
   assign rsp_saturated = sat_ff;

endmodule
